>>> sv/plic_pkg.sv
// ----------------------------------------------------------------------------
// plic_pkg
// Types and constants shared by the interrupt controller modules.
// ----------------------------------------------------------------------------
package plic_pkg;

    localparam int NumSources   = 32;
    localparam int NumContexts  = 2;
    localparam int PrioBits     = 3;
    localparam int IdBits       = 5;

    localparam logic [1:0] REQ_READ   = 2'd0;
    localparam logic [1:0] REQ_WRITE  = 2'd1;
    localparam logic [1:0] REQ_LEVEL  = 2'd2;
    localparam logic [1:0] REQ_UNUSED = 2'd3;

    typedef struct packed {
        logic [1:0]  req_type;
        logic [25:0] addr;
        logic [31:0] wdata;
        logic [9:0]  source_id;
        logic        source_level;
    } plic_in_t;

    typedef struct packed {
        logic [31:0] rdata;
        logic        access_error;
        logic [1:0]  irq_lines;
    } plic_out_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READ,
        ST_EXEC,
        ST_SCAN,
        ST_OUT
    } plic_state_t;

    // Decoded register class.
    typedef enum logic [2:0] {
        RG_BAD,
        RG_PRIO,
        RG_PEND,
        RG_ENABLE,
        RG_THRESH,
        RG_CLAIM
    } plic_reg_t;

endpackage

>>> sv/plic_prio_ram.sv
// ----------------------------------------------------------------------------
// plic_prio_ram
// Source priority memory, one write port and one registered read port.
// ----------------------------------------------------------------------------
module plic_prio_ram
    import plic_pkg::*;
(
    input  logic                clk,
    input  logic                we,
    input  logic [IdBits-1:0]   waddr,
    input  logic [PrioBits-1:0] wdata,
    input  logic [IdBits-1:0]   raddr,
    output logic [PrioBits-1:0] rdata
);

    logic [PrioBits-1:0] mem [NumSources];

    // Write and read in the clock domain.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

>>> sv/platform_interrupt_controller_core.sv
// ----------------------------------------------------------------------------
// platform_interrupt_controller_core
// Platform-level interrupt controller: priorities, pending, enables,
// thresholds and claim/complete for two contexts.
//
//  Channel | Dir | Type       | Handshake
//  in      | in  | plic_in_t  | in_valid / in_stall
//  out     | out | plic_out_t | out_valid / out_stall
//
// Each transaction runs through these steps: the idle state accepts it, a
// sweep over the priority memory (one read per cycle) finds the winners
// before the update, the EXEC state applies the update, a second sweep finds
// the winners after it, and the OUT state presents the result. Priority memory
// has no reset; a valid bit per source makes unwritten entries read as zero.
// Reset clears all control state. A stalled output holds and blocks new input.
// ----------------------------------------------------------------------------
module platform_interrupt_controller_core
    import plic_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_stall,
    input  plic_in_t  in_data,
    output logic      out_valid,
    input  logic      out_stall,
    output plic_out_t out_data
);

    plic_state_t state_reg, state_next;
    plic_in_t    req_reg;
    logic [NumSources-1:0] pend_reg, insvc_reg, lvl_reg, pvalid_reg;
    logic [NumSources-1:0] en_reg [NumContexts];
    logic [PrioBits-1:0]   thr_reg [NumContexts];
    logic [IdBits:0]       scan_reg;
    logic                  pass_reg;
    logic [IdBits-1:0]     best_reg [NumContexts];
    logic [PrioBits-1:0]   bpr_reg [NumContexts];
    plic_out_t             out_reg;
    logic [31:0]           rd_reg;
    logic                  err_reg;

    logic                  ram_we;
    logic [IdBits-1:0]     ram_raddr, ram_waddr;
    logic [PrioBits-1:0]   ram_rdata, ram_wdata, prio_eff;
    plic_reg_t             rclass;
    logic                  rctx;
    logic [IdBits-1:0]     sid_prev;

    plic_prio_ram u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // Decode the register address.
    always_comb
    begin
        logic [25:0] a;
        a = req_reg.addr;
        rclass = RG_BAD;
        rctx   = 1'b0;
        if (a[1:0] == 2'b00)
        begin
            if (a < 26'(4 * NumSources))
                rclass = RG_PRIO;
            else if (a == 26'h1000)
                rclass = RG_PEND;
            else if (a == 26'h2000 || a == 26'h2080)
            begin
                rclass = RG_ENABLE;
                rctx   = a[7];
            end
            else if (a == 26'h200000 || a == 26'h201000)
            begin
                rclass = RG_THRESH;
                rctx   = a[12];
            end
            else if (a == 26'h200004 || a == 26'h201004)
            begin
                rclass = RG_CLAIM;
                rctx   = a[12];
            end
        end
    end

    // Memory ports: sweep during SCAN, requested priority word on the last
    // sweep cycle so that it is ready for EXEC.
    assign sid_prev  = scan_reg[IdBits-1:0] - IdBits'(1);
    assign ram_raddr = (state_reg == ST_SCAN && scan_reg != 6'(NumSources))
                       ? scan_reg[IdBits-1:0] : req_reg.addr[IdBits+1:2];
    assign ram_we    = (state_reg == ST_EXEC) && (req_reg.req_type == REQ_WRITE)
                       && (rclass == RG_PRIO) && (req_reg.addr[IdBits+1:2] != '0);
    assign ram_waddr = req_reg.addr[IdBits+1:2];
    assign ram_wdata = req_reg.wdata[PrioBits-1:0];
    assign prio_eff  = pvalid_reg[sid_prev] ? ram_rdata : '0;

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: if (in_valid) state_next = ST_SCAN;
            ST_SCAN: if (scan_reg == 6'(NumSources)) state_next = pass_reg ? ST_OUT : ST_EXEC;
            ST_EXEC: state_next = ST_SCAN;
            ST_OUT:  if (!out_stall) state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    // Handshake outputs.
    always_comb
    begin
        in_stall  = (state_reg != ST_IDLE);
        out_valid = (state_reg == ST_OUT);
        out_data  = out_reg;
    end

    // Datapath and control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            pend_reg   <= '0;
            insvc_reg  <= '0;
            lvl_reg    <= '0;
            pvalid_reg <= '0;
            scan_reg   <= '0;
            pass_reg   <= 1'b0;
            for (int c = 0; c < NumContexts; c++)
            begin
                en_reg[c]  <= '0;
                thr_reg[c] <= '0;
            end
        end
        else
        begin
            state_reg <= state_next;
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (in_valid)
                    begin
                        req_reg  <= in_data;
                        scan_reg <= '0;
                        pass_reg <= 1'b0;
                        for (int c = 0; c < NumContexts; c++)
                        begin
                            best_reg[c] <= '0;
                            bpr_reg[c]  <= thr_reg[c];
                        end
                    end
                end
                ST_SCAN:
                begin
                    // Compare the entry read on the previous cycle.
                    if (scan_reg != '0)
                    begin
                        for (int c = 0; c < NumContexts; c++)
                        begin
                            if (sid_prev != '0 && pend_reg[sid_prev]
                                && en_reg[c][sid_prev] && prio_eff > bpr_reg[c])
                            begin
                                best_reg[c] <= sid_prev;
                                bpr_reg[c]  <= prio_eff;
                            end
                        end
                    end
                    if (scan_reg == 6'(NumSources))
                    begin
                        if (pass_reg)
                        begin
                            out_reg.rdata        <= rd_reg;
                            out_reg.access_error <= err_reg;
                            for (int c = 0; c < NumContexts; c++)
                                out_reg.irq_lines[c] <= (best_reg[c] != '0) ||
                                    (sid_prev != '0 && pend_reg[sid_prev]
                                     && en_reg[c][sid_prev] && prio_eff > bpr_reg[c]);
                        end
                    end
                    else
                        scan_reg <= scan_reg + 6'd1;
                end
                ST_EXEC:
                begin
                    logic [NumSources-1:0] p, s, l;
                    logic [IdBits-1:0] win;
                    p = pend_reg; s = insvc_reg; l = lvl_reg;
                    rd_reg  <= '0;
                    err_reg <= 1'b0;
                    win = best_reg[rctx];
                    if (req_reg.req_type == REQ_LEVEL)
                    begin
                        if (req_reg.source_id != '0 && req_reg.source_id < 10'(NumSources))
                            l[req_reg.source_id[IdBits-1:0]] = req_reg.source_level;
                    end
                    else if (req_reg.req_type == REQ_READ || req_reg.req_type == REQ_WRITE)
                    begin
                        case (rclass)
                            RG_PRIO:
                                if (req_reg.req_type == REQ_WRITE)
                                begin
                                    if (ram_we)
                                        pvalid_reg[ram_waddr] <= 1'b1;
                                end
                                else
                                    rd_reg <= 32'(pvalid_reg[ram_waddr] ? ram_rdata : '0);
                            RG_PEND:
                                if (req_reg.req_type == REQ_READ)
                                    rd_reg <= 32'(pend_reg & ~32'd1);
                            RG_ENABLE:
                                if (req_reg.req_type == REQ_WRITE)
                                    en_reg[rctx] <= req_reg.wdata & ~32'd1;
                                else
                                    rd_reg <= en_reg[rctx];
                            RG_THRESH:
                                if (req_reg.req_type == REQ_WRITE)
                                    thr_reg[rctx] <= req_reg.wdata[PrioBits-1:0];
                                else
                                    rd_reg <= 32'(thr_reg[rctx]);
                            RG_CLAIM:
                                if (req_reg.req_type == REQ_WRITE)
                                begin
                                    if (req_reg.wdata != '0 && req_reg.wdata < 32'(NumSources))
                                        s[req_reg.wdata[IdBits-1:0]] = 1'b0;
                                end
                                else
                                begin
                                    if (win != '0)
                                    begin
                                        p[win] = 1'b0;
                                        s[win] = 1'b1;
                                    end
                                    rd_reg <= 32'(win);
                                end
                            default: err_reg <= 1'b1;
                        endcase
                    end
                    // Gateways: level high and not in service sets pending.
                    p = (p | (l & ~s)) & ~32'd1;
                    pend_reg  <= p;
                    insvc_reg <= s;
                    lvl_reg   <= l;
                    scan_reg  <= '0;
                    pass_reg  <= 1'b1;
                    for (int c = 0; c < NumContexts; c++)
                    begin
                        best_reg[c] <= '0;
                        bpr_reg[c]  <= (req_reg.req_type == REQ_WRITE && rclass == RG_THRESH
                                        && rctx == c[0]) ? req_reg.wdata[PrioBits-1:0]
                                                         : thr_reg[c];
                    end
                end
                default: ;
            endcase
        end
    end

endmodule
